// File: hdl/tle_pkg.sv
// Shared types and constants for the toroidal Life engine.
// No dependencies; the engine, cell and sequencer files in hdl/ refer to this package.
`default_nettype none

package tle_pkg;

  localparam int ROWS_DEF      = 8;
  localparam int COL_BYTES_DEF = 4;

  localparam logic [7:0] DIV_RESET = 8'd16;

  // Restoring remainder: highest shift of the divider that can fit a 9-bit value
  localparam logic [3:0] MOD_TOP_SHIFT = 4'd8;

  // Rule B3/S23 expressed as 16*self + neighbours
  localparam logic [4:0] LIFE_BIRTH   = 5'd3;
  localparam logic [4:0] LIFE_SURV_LO = 5'd18;
  localparam logic [4:0] LIFE_SURV_HI = 5'd19;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_MOD     = 2'd1,
    ST_COMPUTE = 2'd2
  } state_t;

  // Commands broadcast to every row cell
  typedef struct packed {
    logic copy;   // load the pending generation onto the display
    logic step;   // rotate one column and evaluate one cell
  } cell_ctl_t;

  // Tick result handed from the sequencer to the output register
  typedef struct packed {
    logic done;
    logic shown;
    logic computed;
  } tick_res_t;

endpackage

`default_nettype wire

// File: hdl/tle_in_if.sv
// Input channel of the Life engine: valid/ready plus one request item.
// Depends on nothing.
`default_nettype none

interface tle_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [2:0] row_index;
  logic [1:0] byte_column;
  logic [7:0] pixel_byte;

  modport source (output valid, output op, output row_index, output byte_column,
                  output pixel_byte, input ready);
  modport sink   (input valid, input op, input row_index, input byte_column,
                  input pixel_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/tle_out_if.sv
// Result channel of the Life engine: valid/ready plus one result item.
// Depends on nothing.
`default_nettype none

interface tle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       generation_shown;
  logic       generation_computed;

  modport source (output valid, output read_byte, output generation_shown,
                  output generation_computed, input ready);
  modport sink   (input valid, input read_byte, input generation_shown,
                  input generation_computed, output ready);
endinterface

`default_nettype wire

// File: hdl/toroidal_life_engine.sv
// Toroidal Life engine: a ring of row cells sweeps one column per cycle.
// Reads, writes and ticks needing no remainder register their result in the cycle after
// acceptance; a tick after the divider fell to or below the count runs the nine-step
// remainder unit first. Input takes one item per cycle unless a result is waiting or
// the sequencer runs the remainder unit or a column sweep. Reset (synchronous, rst_n
// low) clears display, pending rows, counter and the pending and valid flags at once.
`default_nettype none

module toroidal_life_engine #(
  parameter int ROWS      = tle_pkg::ROWS_DEF,
  parameter int COL_BYTES = tle_pkg::COL_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  tle_in_if.sink          in_ch,
  tle_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data
);

  localparam int NCOLS = COL_BYTES * 8;

  tle_pkg::cell_ctl_t cell_ctl;
  tle_pkg::tick_res_t tick_res;
  logic               busy;
  logic               in_acc;
  logic               tick_acc;
  logic               wr_acc;
  logic               rd_acc;
  logic [7:0]         rd_byte;
  logic [2:0]         win_w    [ROWS];
  logic [NCOLS-1:0]   row_bits [ROWS];

  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         rd_byte_r, rd_byte_nxt;
  logic               shown_r, shown_nxt;
  logic               computed_r, computed_nxt;

  assign in_ch.ready = !busy && (!out_valid_r || out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    tick_acc = 1'b0;
    wr_acc   = 1'b0;
    rd_acc   = 1'b0;
    unique case (tle_pkg::op_t'(in_ch.op))
      tle_pkg::OP_TICK:  tick_acc = in_acc;
      tle_pkg::OP_WRITE: wr_acc   = in_acc;
      tle_pkg::OP_READ:  rd_acc   = in_acc;
      default: ;
    endcase
  end

  tle_ctrl #(.COL_BYTES(COL_BYTES)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick_acc (tick_acc),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .busy     (busy),
    .cell_ctl (cell_ctl),
    .tick_res (tick_res)
  );

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    tle_cell #(.COL_BYTES(COL_BYTES)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cell_ctl),
      .wr_en    (wr_acc && (32'(in_ch.row_index) == r)),
      .wr_col   (in_ch.byte_column),
      .wr_data  (in_ch.pixel_byte),
      .up_win   (win_w[(r + ROWS - 1) % ROWS]),
      .dn_win   (win_w[(r + 1) % ROWS]),
      .win      (win_w[r]),
      .row_bits (row_bits[r])
    );
  end

  // Addresses beyond the bitmap match no row or byte and read as zero
  always_comb begin
    rd_byte = 8'd0;
    for (int r = 0; r < ROWS; r++) begin
      for (int b = 0; b < COL_BYTES; b++) begin
        if ((32'(in_ch.row_index) == r) && (32'(in_ch.byte_column) == b)) begin
          rd_byte = row_bits[r][NCOLS-1-8*b -: 8];
        end
      end
    end
  end

  // Reads and writes answer at once; ticks answer when the sequencer has the flags
  always_comb begin
    out_valid_nxt = out_valid_r;
    rd_byte_nxt   = rd_byte_r;
    shown_nxt     = shown_r;
    computed_nxt  = computed_r;
    priority if (tick_res.done) begin
      out_valid_nxt = 1'b1;
      rd_byte_nxt   = 8'd0;
      shown_nxt     = tick_res.shown;
      computed_nxt  = tick_res.computed;
    end else if (in_acc && !tick_acc) begin
      out_valid_nxt = 1'b1;
      rd_byte_nxt   = rd_acc ? rd_byte : 8'd0;
      shown_nxt     = 1'b0;
      computed_nxt  = 1'b0;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_byte_r  <= rd_byte_nxt;
    shown_r    <= shown_nxt;
    computed_r <= computed_nxt;
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.read_byte           = rd_byte_r;
  assign out_ch.generation_shown    = shown_r;
  assign out_ch.generation_computed = computed_r;

endmodule

`default_nettype wire

// File: hdl/tle_cell.sv
// One display row of the Life engine: display and pending row registers,
// column rotation and the per-pixel rule. Depends on tle_pkg.
`default_nettype none

module tle_cell #(
  parameter int COL_BYTES = tle_pkg::COL_BYTES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire tle_pkg::cell_ctl_t       ctl,
  input  wire logic                     wr_en,
  input  wire logic [1:0]               wr_col,
  input  wire logic [7:0]               wr_data,
  input  wire logic [2:0]               up_win,
  input  wire logic [2:0]               dn_win,
  output      logic [2:0]               win,
  output      logic [COL_BYTES*8-1:0]   row_bits
);

  localparam int NCOLS = COL_BYTES * 8;

  logic [NCOLS-1:0] row_r, row_nxt;
  logic [NCOLS-1:0] pend_r, pend_nxt;
  logic [3:0]       nbr_cnt;
  logic [4:0]       score;
  logic             alive;

  // Column under evaluation sits at the top bit; left and right wrap round
  assign win      = {row_r[0], row_r[NCOLS-1], row_r[NCOLS-2]};
  assign row_bits = row_r;

  always_comb begin
    nbr_cnt = 4'(up_win[0]) + 4'(up_win[1]) + 4'(up_win[2])
            + 4'(dn_win[0]) + 4'(dn_win[1]) + 4'(dn_win[2])
            + 4'(win[2]) + 4'(win[0]);
    score   = {win[1], 4'b0000} + 5'(nbr_cnt);
    alive   = (score == tle_pkg::LIFE_BIRTH) || (score == tle_pkg::LIFE_SURV_LO) ||
              (score == tle_pkg::LIFE_SURV_HI);
  end

  always_comb begin
    row_nxt  = row_r;
    pend_nxt = pend_r;
    priority if (ctl.copy) begin
      row_nxt = pend_r;
    end else if (ctl.step) begin
      row_nxt  = {row_r[NCOLS-2:0], row_r[NCOLS-1]};
      pend_nxt = {pend_r[NCOLS-2:0], alive};
    end else if (wr_en) begin
      for (int b = 0; b < COL_BYTES; b++) begin
        if (32'(wr_col) == b) begin
          row_nxt[NCOLS-1-8*b -: 8] = wr_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      pend_r <= '0;
    end else begin
      row_r  <= row_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/tle_ctrl.sv
// Sequencer of the Life engine: divider register, prescale counter with its
// remainder unit, pending flag and the column sweep. Depends on tle_pkg.
`default_nettype none

module tle_ctrl #(
  parameter int COL_BYTES = tle_pkg::COL_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                tick_acc,
  input  wire logic                cfg_we,
  input  wire logic [7:0]          cfg_data,
  output      logic                busy,
  output      tle_pkg::cell_ctl_t  cell_ctl,
  output      tle_pkg::tick_res_t  tick_res
);

  localparam int NCOLS = COL_BYTES * 8;
  localparam int StepW = $clog2(NCOLS);

  tle_pkg::state_t  state_r, state_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic [7:0]       div_r, div_nxt;
  logic [7:0]       cnt_r, cnt_nxt;
  logic             pend_rdy_r, pend_rdy_nxt;
  logic             shown_r, shown_nxt;
  logic [8:0]       mod_v_r, mod_v_nxt;
  logic [3:0]       mod_i_r, mod_i_nxt;

  logic [7:0]       div_eff;
  logic [8:0]       cnt_inc;
  logic [16:0]      mod_sub;
  logic [8:0]       mod_rem;
  logic             step_last;

  assign div_eff   = (div_r == 8'd0) ? 8'd1 : div_r;
  assign cnt_inc   = {1'b0, cnt_r} + 9'd1;
  assign step_last = (step_r == StepW'(NCOLS - 1));

  // One restoring step: drop the shifted divider if it fits
  always_comb begin
    mod_sub = 17'(div_eff) << mod_i_r;
    mod_rem = mod_v_r;
    if (17'(mod_v_r) >= mod_sub) begin
      mod_rem = 9'(17'(mod_v_r) - mod_sub);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tle_pkg::ST_IDLE: begin
        if (tick_acc) begin
          priority if (cnt_inc > 9'(div_eff)) begin
            state_nxt = tle_pkg::ST_MOD;
          end else if (cnt_inc == 9'(div_eff)) begin
            state_nxt = tle_pkg::ST_COMPUTE;
          end else begin
            state_nxt = tle_pkg::ST_IDLE;
          end
        end
      end
      tle_pkg::ST_MOD: begin
        if (mod_i_r == 4'd0) begin
          state_nxt = (mod_rem == 9'd0) ? tle_pkg::ST_COMPUTE : tle_pkg::ST_IDLE;
        end
      end
      tle_pkg::ST_COMPUTE: begin
        if (step_last) begin
          state_nxt = tle_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tle_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy              = 1'b1;
    cell_ctl          = '0;
    tick_res          = '0;
    unique case (state_r)
      tle_pkg::ST_IDLE: begin
        busy          = 1'b0;
        cell_ctl.copy = tick_acc && pend_rdy_r;
        if (tick_acc && (cnt_inc <= 9'(div_eff))) begin
          tick_res.done     = 1'b1;
          tick_res.shown    = pend_rdy_r;
          tick_res.computed = (cnt_inc == 9'(div_eff));
        end
      end
      tle_pkg::ST_MOD: begin
        if (mod_i_r == 4'd0) begin
          tick_res.done     = 1'b1;
          tick_res.shown    = shown_r;
          tick_res.computed = (mod_rem == 9'd0);
        end
      end
      tle_pkg::ST_COMPUTE: begin
        cell_ctl.step = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  // Counters and flags
  always_comb begin
    div_nxt      = cfg_we ? cfg_data : div_r;
    cnt_nxt      = cnt_r;
    pend_rdy_nxt = pend_rdy_r;
    shown_nxt    = shown_r;
    mod_v_nxt    = mod_v_r;
    mod_i_nxt    = mod_i_r;
    step_nxt     = step_r;
    unique case (state_r)
      tle_pkg::ST_IDLE: begin
        if (tick_acc) begin
          pend_rdy_nxt = 1'b0;
          shown_nxt    = pend_rdy_r;
          mod_v_nxt    = cnt_inc;
          mod_i_nxt    = tle_pkg::MOD_TOP_SHIFT;
          if (cnt_inc < 9'(div_eff)) begin
            cnt_nxt = cnt_inc[7:0];
          end else if (cnt_inc == 9'(div_eff)) begin
            cnt_nxt = 8'd0;
          end
        end
      end
      tle_pkg::ST_MOD: begin
        mod_v_nxt = mod_rem;
        if (mod_i_r == 4'd0) begin
          cnt_nxt = mod_rem[7:0];
        end else begin
          mod_i_nxt = mod_i_r - 4'd1;
        end
      end
      tle_pkg::ST_COMPUTE: begin
        if (step_last) begin
          step_nxt     = '0;
          pend_rdy_nxt = 1'b1;
        end else begin
          step_nxt = step_r + StepW'(1);
        end
      end
      default: step_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= tle_pkg::ST_IDLE;
      step_r     <= '0;
      div_r      <= tle_pkg::DIV_RESET;
      cnt_r      <= 8'd0;
      pend_rdy_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      div_r      <= div_nxt;
      cnt_r      <= cnt_nxt;
      pend_rdy_r <= pend_rdy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shown_r <= shown_nxt;
    mod_v_r <= mod_v_nxt;
    mod_i_r <= mod_i_nxt;
  end

`ifndef NO_ASSERTIONS
  a_copy_not_step: assert property (@(posedge clk) disable iff (!rst_n)
    !(cell_ctl.copy && cell_ctl.step))
    else $error("display load and column sweep at once");

  a_computed_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_res.done && tick_res.computed) |=> (state_r == tle_pkg::ST_COMPUTE))
    else $error("computed tick without a column sweep");

  a_step_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != tle_pkg::ST_COMPUTE) |-> (step_r == '0))
    else $error("column counter left non-zero outside the sweep");

  a_pending_drop: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(pend_rdy_r) && $past(rst_n)) |-> $past(cell_ctl.copy))
    else $error("pending generation dropped without being shown");
`endif

endmodule

`default_nettype wire
